// File: src/tlic_pkg.sv
package tlic_pkg;

  localparam int unsigned INDEX_BITS_DEF = 24;
  localparam int unsigned LEVELS_W       = 10;
  localparam int unsigned SRCH_W         = 12;
  localparam int unsigned PROD_W         = 38;
  localparam int unsigned ROWP_W         = 28;
  localparam int unsigned COL6_W         = 15;
  localparam int unsigned RCP_W          = 29;
  localparam int unsigned RECIP6         = 10923;
  localparam int unsigned Q16_SHIFT      = 17;
  localparam int unsigned DIV_N_W        = SRCH_W + Q16_SHIFT + 1;
  localparam int unsigned DIV_D_W        = LEVELS_W + 1;
  localparam int unsigned SMALL_W        = 9;
  localparam int unsigned XY_W           = 25;
  localparam int unsigned Z_W            = 26;
  localparam int unsigned Z_ONE          = 65536;
  localparam int unsigned OUT_W          = 1 + 3 * SMALL_W + 2 * XY_W + Z_W;

  typedef struct packed {
    logic [SRCH_W-1:0] m;
    logic [PROD_W-1:0] t6;
    logic [PROD_W-1:0] idx6;
  } layer_t;

  typedef struct packed {
    logic [SRCH_W-1:0]  m;
    logic [PROD_W-1:0]  r6;
    logic [SRCH_W+1:0]  k21;
    logic [SRCH_W-1:0]  i;
    logic [ROWP_W-1:0]  w;
  } row_t;

  typedef struct packed {
    logic [SRCH_W-1:0] m;
    logic [SRCH_W-1:0] i;
    logic [SRCH_W-1:0] col;
    logic              neg;
  } ctx_t;

endpackage

// File: src/tlic_layer.sv
module tlic_layer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [tlic_pkg::PROD_W-1:0] idx6_i,
  output logic                       valid_o,
  output tlic_pkg::layer_t           data_o
);

  localparam int unsigned SW = tlic_pkg::SRCH_W;
  localparam int unsigned PW = tlic_pkg::PROD_W;
  localparam int unsigned AW = 2 * SW + 1;

  logic             va_q [SW];
  tlic_pkg::layer_t a_q  [SW];
  logic [SW-1:0]    c_q  [SW];
  logic [AW-1:0]    p_q  [SW];
  logic             vb_q [SW];
  tlic_pkg::layer_t b_q  [SW];

  for (genvar s = 0; s < SW; s++) begin : g_step
    tlic_pkg::layer_t prev;
    logic             prev_v;
    logic [SW-1:0]    c;
    logic [PW-1:0]    t;
    tlic_pkg::layer_t nxt;

    if (s == 0) begin : g_first
      assign prev_v = valid_i;
      assign prev   = '{m: '0, t6: '0, idx6: idx6_i};
    end else begin : g_next
      assign prev_v = vb_q[s-1];
      assign prev   = b_q[s-1];
    end

    assign c = prev.m | (SW'(1) << (SW - 1 - s));
    assign t = PW'(p_q[s]) * PW'({1'b0, c_q[s]} + (SW + 1)'(2));

    always_comb begin
      nxt = a_q[s];
      if (t <= a_q[s].idx6) begin
        nxt.m  = c_q[s];
        nxt.t6 = t;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        va_q[s] <= 1'b0;
        vb_q[s] <= 1'b0;
      end else if (en_i) begin
        va_q[s] <= prev_v;
        vb_q[s] <= va_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[s] <= prev;
        c_q[s] <= c;
        p_q[s] <= AW'(c) * AW'({1'b0, c} + (SW + 1)'(1));
        b_q[s] <= nxt;
      end
    end
  end

  assign valid_o = vb_q[SW-1];
  assign data_o  = b_q[SW-1];

endmodule

// File: src/tlic_row.sv
module tlic_row (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  tlic_pkg::layer_t data_i,
  output logic             valid_o,
  output tlic_pkg::ctx_t   data_o
);

  localparam int unsigned SW = tlic_pkg::SRCH_W;
  localparam int unsigned PW = tlic_pkg::PROD_W;
  localparam int unsigned RW = tlic_pkg::ROWP_W;
  localparam int unsigned CW = tlic_pkg::COL6_W;
  localparam int unsigned MW = tlic_pkg::RCP_W;

  logic           v0_q;
  tlic_pkg::row_t r0_q;
  logic           vs_q [SW];
  tlic_pkg::row_t rs_q [SW];
  logic           vf_q;
  logic [SW-1:0]  fm_q, fi_q;
  logic [CW-1:0]  col6_q;
  logic           vo_q;
  tlic_pkg::ctx_t o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r0_q.m   <= data_i.m;
      r0_q.r6  <= data_i.idx6 - data_i.t6;
      r0_q.k21 <= {1'b0, data_i.m, 1'b0} + (SW + 2)'(3);
      r0_q.i   <= '0;
      r0_q.w   <= '0;
    end
  end

  for (genvar s = 0; s < SW; s++) begin : g_step
    tlic_pkg::row_t prev;
    logic           prev_v;
    logic [SW-1:0]  c;
    logic [SW+1:0]  val;
    logic [RW-1:0]  prod;
    logic [RW-1:0]  w;
    tlic_pkg::row_t nxt;

    if (s == 0) begin : g_first
      assign prev_v = v0_q;
      assign prev   = r0_q;
    end else begin : g_next
      assign prev_v = vs_q[s-1];
      assign prev   = rs_q[s-1];
    end

    assign c    = prev.i | (SW'(1) << (SW - 1 - s));
    assign val  = prev.k21 - (SW + 2)'(c);
    assign prod = RW'(c) * RW'(val);
    assign w    = (prod << 1) + prod;

    always_comb begin
      nxt = prev;
      if ((c <= prev.m) && (PW'(w) <= prev.r6)) begin
        nxt.i = c;
        nxt.w = w;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[s] <= 1'b0;
      end else if (en_i) begin
        vs_q[s] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rs_q[s] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      vf_q <= vs_q[SW-1];
      vo_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fm_q     <= rs_q[SW-1].m;
      fi_q     <= rs_q[SW-1].i;
      col6_q   <= CW'(rs_q[SW-1].r6 - PW'(rs_q[SW-1].w));
      o_q.m    <= fm_q;
      o_q.i    <= fi_q;
      o_q.col  <= SW'((MW'(col6_q) * MW'(tlic_pkg::RECIP6)) >> 16);
      o_q.neg  <= 1'b0;
    end
  end

  assign valid_o = vo_q;
  assign data_o  = o_q;

endmodule

// File: src/tlic_div.sv
module tlic_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [tlic_pkg::DIV_D_W-1:0] d_i,
  input  logic                         valid_i,
  input  logic [tlic_pkg::DIV_N_W-1:0] n_i [3],
  input  tlic_pkg::ctx_t               side_i,
  output logic                         valid_o,
  output logic [tlic_pkg::DIV_N_W-1:0] q_o [3],
  output tlic_pkg::ctx_t               side_o
);

  localparam int unsigned NW = tlic_pkg::DIV_N_W;
  localparam int unsigned DW = tlic_pkg::DIV_D_W;

  logic           v_q    [NW];
  tlic_pkg::ctx_t side_q [NW];
  logic [DW-1:0]  rem_q  [NW][3];
  logic [NW-1:0]  n_q    [NW][3];
  logic [NW-1:0]  q_q    [NW][3];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic           pv;
    tlic_pkg::ctx_t ps;

    if (s == 0) begin : g_first
      assign pv = valid_i;
      assign ps = side_i;
    end else begin : g_next
      assign pv = v_q[s-1];
      assign ps = side_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= ps;
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [DW-1:0] pr;
      logic [NW-1:0] pn, pq;
      logic [DW:0]   t;
      logic          ge;

      if (s == 0) begin : g_first
        assign pr = '0;
        assign pn = n_i[l];
        assign pq = '0;
      end else begin : g_next
        assign pr = rem_q[s-1][l];
        assign pn = n_q[s-1][l];
        assign pq = q_q[s-1][l];
      end

      assign t  = {pr, pn[NW-1]};
      assign ge = t >= {1'b0, d_i};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s][l] <= ge ? DW'(t - {1'b0, d_i}) : t[DW-1:0];
          n_q[s][l]   <= pn << 1;
          q_q[s][l]   <= {pq[NW-2:0], ge};
        end
      end
    end
  end

  assign valid_o = v_q[NW-1];
  assign side_o  = side_q[NW-1];
  assign q_o[0]  = q_q[NW-1][0];
  assign q_o[1]  = q_q[NW-1][1];
  assign q_o[2]  = q_q[NW-1][2];

endmodule

// File: src/tet_lattice_index_to_coords.sv
// Pipeline: the 12-step layer search (two multiplier stages a step), the 12-step row search
//   and the 30-stage divider.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset: rst_ni is asynchronous, active low; it empties the pipeline and sets levels to 1.
module tet_lattice_index_to_coords #(
  parameter int unsigned INDEX_BITS = tlic_pkg::INDEX_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // point_index
  input  logic [((INDEX_BITS+7)/8)*8-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status, layer, row, column, x_q16, y_q16, z_q16
  output logic [tlic_pkg::OUT_W-1:0]        m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tlic_pkg::LEVELS_W-1:0]     cfg_data_i
);

  localparam int unsigned PW = tlic_pkg::PROD_W;
  localparam int unsigned SW = tlic_pkg::SRCH_W;
  localparam int unsigned NW = tlic_pkg::DIV_N_W;
  localparam int unsigned LW = tlic_pkg::LEVELS_W;

  logic [LW-1:0]    levels_q;
  logic             en;
  logic             v_in_q;
  logic [PW-1:0]    idx6_q;
  logic             lay_v;
  tlic_pkg::layer_t lay_d;
  logic             row_v;
  tlic_pkg::ctx_t   row_d;
  logic             vp_q;
  tlic_pkg::ctx_t   ctx_q;
  logic [NW-1:0]    n_q [3];
  logic             div_v;
  logic [NW-1:0]    q   [3];
  tlic_pkg::ctx_t   div_s;
  logic [SW-1:0]    mag;
  logic             neg;
  logic [NW-1:0]    zq;
  logic             m_tvalid_q;
  logic [tlic_pkg::OUT_W-1:0] out_q, out_d;

  assign en            = !m_tvalid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= LW'(1);
    end else if (cfg_valid_i) begin
      levels_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_in_q     <= 1'b0;
      vp_q       <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else if (en) begin
      v_in_q     <= s_axis_tvalid;
      vp_q       <= row_v;
      m_tvalid_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx6_q <= (PW'(s_axis_tdata[INDEX_BITS-1:0]) << 2)
              + (PW'(s_axis_tdata[INDEX_BITS-1:0]) << 1);
    end
  end

  tlic_layer u_layer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_in_q),
    .idx6_i  (idx6_q),
    .valid_o (lay_v),
    .data_o  (lay_d)
  );

  tlic_row u_row (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (lay_v),
    .data_i  (lay_d),
    .valid_o (row_v),
    .data_o  (row_d)
  );

  assign neg = row_d.m > SW'(levels_q);
  assign mag = neg ? row_d.m - SW'(levels_q) : SW'(levels_q) - row_d.m;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_q     <= '{m: row_d.m, i: row_d.i, col: row_d.col, neg: neg};
      n_q[0]    <= (NW'(row_d.col) << tlic_pkg::Q16_SHIFT) + NW'(levels_q);
      n_q[1]    <= (NW'(row_d.i) << tlic_pkg::Q16_SHIFT) + NW'(levels_q);
      n_q[2]    <= (NW'(mag) << tlic_pkg::Q16_SHIFT) + NW'(levels_q);
    end
  end

  tlic_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .d_i     ({levels_q, 1'b0}),
    .valid_i (vp_q),
    .n_i     (n_q),
    .side_i  (ctx_q),
    .valid_o (div_v),
    .q_o     (q),
    .side_o  (div_s)
  );

  assign zq = div_s.neg ? NW'(0) - q[2] : q[2];

  always_comb begin
    if (levels_q == '0) begin
      out_d    = '0;
      out_d[0] = div_s.m != '0;
      out_d[tlic_pkg::OUT_W-1 -: tlic_pkg::Z_W] =
        (div_s.m == '0) ? tlic_pkg::Z_W'(tlic_pkg::Z_ONE) : '0;
    end else begin
      out_d = {zq[tlic_pkg::Z_W-1:0], q[1][tlic_pkg::XY_W-1:0], q[0][tlic_pkg::XY_W-1:0],
               div_s.col[tlic_pkg::SMALL_W-1:0], div_s.i[tlic_pkg::SMALL_W-1:0],
               div_s.m[tlic_pkg::SMALL_W-1:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTH
  a_ok_when_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_v && levels_q != '0) |-> !out_d[0])
    else $error("error flag set with nonzero levels");
  a_row_le_layer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_v |-> (div_s.i <= div_s.m))
    else $error("row exceeds layer");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && !m_axis_tready) |=> (m_tvalid_q && $stable(out_q)))
    else $error("pipeline advanced during stall");
`endif

endmodule

// File: tb/tet_lattice_index_to_coords_tb.sv
module tet_lattice_index_to_coords_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned IDX_W        = 24;
  localparam int unsigned LW           = tlic_pkg::LEVELS_W;
  localparam int unsigned SMW          = tlic_pkg::SMALL_W;
  localparam int unsigned XYW          = tlic_pkg::XY_W;
  localparam int unsigned ZW           = tlic_pkg::Z_W;
  localparam int unsigned OW           = tlic_pkg::OUT_W;
  localparam int unsigned SRW          = tlic_pkg::SRCH_W;
  localparam int unsigned ZONE         = tlic_pkg::Z_ONE;

  typedef struct packed {
    logic [ZW-1:0]  z;
    logic [XYW-1:0] y;
    logic [XYW-1:0] x;
    logic [SMW-1:0] column;
    logic [SMW-1:0] row;
    logic [SMW-1:0] layer;
    logic           err;
  } coords_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IDX_W-1:0] s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OW-1:0]    m_axis_tdata;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [LW-1:0]    cfg_data_i = '0;

  coords_t          pending_coords[$];
  logic [LW-1:0]    cur_levels;
  int unsigned      src_idle_pct;
  int unsigned      snk_stall_pct;
  logic             hold_off;
  int unsigned      errors;
  int unsigned      cycles;

  tet_lattice_index_to_coords dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // point_index
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // status, layer, row, column, x_q16, y_q16, z_q16
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint unsigned tet_count(longint unsigned m);
    return m * (m + 1) * (m + 2) / 6;
  endfunction

  function automatic longint unsigned rows_before(longint unsigned i, longint unsigned k);
    if (i == 0) return 0;
    return i * k - i * (i - 1) / 2;
  endfunction

  function automatic longint unsigned q16_quot(longint unsigned v, longint unsigned l);
    return ((v << 17) + l) / (2 * l);
  endfunction

  function automatic coords_t predict_coords(logic [IDX_W-1:0] idx, logic [LW-1:0] lv);
    longint unsigned l, m, k, r, i, c, col, mag, zq, xq, yq;
    longint          d;
    coords_t         o;
    o = '0;
    l = lv;
    if (l == 0) begin
      o.err = (idx != 0);
      o.z   = (idx == 0) ? ZW'(ZONE) : '0;
      return o;
    end
    m = 0;
    for (int b = SRW - 1; b >= 0; b--) begin
      if (tet_count(m | (64'd1 << b)) <= idx) m = m | (64'd1 << b);
    end
    k = m + 1;
    r = idx - tet_count(m);
    i = 0;
    for (int b = SRW - 1; b >= 0; b--) begin
      c = i | (64'd1 << b);
      if (c <= k - 1 && rows_before(c, k) <= r) i = c;
    end
    col = r - rows_before(i, k);
    d   = longint'(l) - longint'(m);
    mag = (d < 0) ? longint'(-d) : d;
    zq  = q16_quot(mag, l);
    if (d < 0) zq = -zq;
    xq  = q16_quot(col, l);
    yq  = q16_quot(i, l);
    o.layer  = m[SMW-1:0];
    o.row    = i[SMW-1:0];
    o.column = col[SMW-1:0];
    o.x      = xq[XYW-1:0];
    o.y      = yq[XYW-1:0];
    o.z      = zq[ZW-1:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tet_lattice_index_to_coords verification failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= hold_off ? 1'b0 : ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    coords_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_coords.size() == 0) begin
        report_mismatch("unexpected transfer", got.layer, 0);
      end else begin
        want = pending_coords.pop_front();
        if (got.err != want.err) report_mismatch("status", got.err, want.err);
        if (got.layer != want.layer) report_mismatch("layer", got.layer, want.layer);
        if (got.row != want.row) report_mismatch("row", got.row, want.row);
        if (got.column != want.column) report_mismatch("column", got.column, want.column);
        if (got.x != want.x) report_mismatch("x_q16", got.x, want.x);
        if (got.y != want.y) report_mismatch("y_q16", got.y, want.y);
        if (got.z != want.z) report_mismatch("z_q16", got.z, want.z);
      end
    end
  end

  task automatic send_point(logic [IDX_W-1:0] idx);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= idx;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_coords.push_back(predict_coords(idx, cur_levels));
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    while (pending_coords.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_levels(logic [LW-1:0] lv);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= lv;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cur_levels = lv;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [IDX_W-1:0] lattice_point(logic [LW-1:0] lv);
    longint unsigned top;
    top = tet_count(longint'(lv) + 1) - 1;
    if (top > 24'hFFFFFF) top = 24'hFFFFFF;
    return IDX_W'($urandom_range(0, top));
  endfunction

  task automatic test_directed();
    logic [IDX_W-1:0] pts[$];
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    pts = '{0, 1, 2, 3, 4, 5, 9, 10, 19, 20, 24'hFFFFFF, 24'h800000, 24'h555555, 24'hAAAAAA};
    foreach (pts[n]) send_point(pts[n]);
    stop_sending();
    write_levels('0);
    send_point(0);
    send_point(1);
    send_point(24'hFFFFFF);
    send_point(0);
    stop_sending();
    write_levels(10'h3FF);
    pts = '{0, 1, 1023, 24'hFFFFFF, 24'h2AAAAA, 24'hD55555, 179};
    foreach (pts[n]) send_point(pts[n]);
    stop_sending();
  endtask

  task automatic test_random();
    logic [LW-1:0] lv;
    for (int phase = 0; phase < 8; phase++) begin
      unique case (phase)
        0: lv = 10'h3FF;
        1: lv = '0;
        2: lv = LW'(1);
        3: lv = LW'(2);
        4: lv = LW'(512);
        default: lv = LW'($urandom_range(3, 1023));
      endcase
      write_levels(lv);
      src_idle_pct  = (phase % 4 == 1 || phase % 4 == 3) ? 48 : 0;
      snk_stall_pct = (phase % 4 == 2 || phase % 4 == 3) ? 48 : 0;
      if (phase % 4 == 3) begin
        src_idle_pct  = 24;
        snk_stall_pct = 24;
      end
      repeat (210) begin
        if ($urandom_range(99) < 60) send_point(lattice_point(lv));
        else send_point(IDX_W'($urandom));
      end
      stop_sending();
    end
  endtask

  task automatic test_backpressure();
    write_levels(LW'($urandom_range(1, 1023)));
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    repeat (200) send_point(lattice_point(cur_levels));
    stop_sending();
  endtask

  initial begin
    cur_levels    = 1;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_off      = 1'b0;
    errors        = 0;
    cycles        = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    drain_results();
    if (errors == 0) begin
      $display("tet_lattice_index_to_coords verification clean");
    end else begin
      $display("tet_lattice_index_to_coords verification failed");
    end
    $finish;
  end

endmodule

// File: tet_lattice_index_to_coords.f
src/tlic_pkg.sv
src/tlic_layer.sv
src/tlic_row.sv
src/tlic_div.sv
src/tet_lattice_index_to_coords.sv
tb/tet_lattice_index_to_coords_tb.sv
